// ===== rtl/core/keyframe_pose_interpolator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyframe pose interpolator
// Shared concurrent check forms, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POSE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_POSE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define KPI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kpi: same-cycle check failed");

// next-cycle implication
`define KPI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kpi: next-cycle check failed");

`endif

// ===== rtl/core/kpi_pkg.sv =====
// ----------------------------------------------------------------------------
// kpi_pkg
// Constants, beat payloads and divider handshake types of the keyframe
// pose interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

   localparam int JOINTS     = 18;
   localparam int PAGE_DEPTH = 16;
   localparam int MAX_POINTS = 4095;

   localparam int TYPE_W   = 2;
   localparam int KF_W     = 4;
   localparam int JOINT_W  = 5;
   localparam int POS_W    = 16;
   localparam int DUR_W    = 16;
   localparam int COUNT_W  = 5;
   localparam int PERIOD_W = 10;

   localparam int PERIOD_RESET = 70;

   localparam int KF_IDX_W = $clog2(PAGE_DEPTH);
   localparam int SEG_W    = $clog2(PAGE_DEPTH + 1);
   localparam int STEP_W   = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W   = $clog2(PAGE_DEPTH * JOINTS);
   localparam int DIFF_W   = POS_W + 1;
   localparam int PROD_W   = STEP_W + 1 + DIFF_W;
   localparam int MAG_W    = STEP_W + POS_W;
   localparam int NUM_W    = (MAG_W + 2 > DUR_W + 1) ? MAG_W + 2 : DUR_W + 1;
   localparam int DEN_W    = (STEP_W + 1 > PERIOD_W) ? STEP_W + 1 : PERIOD_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [TYPE_W-1:0] REQ_STORE_POS = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_STORE_DUR = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_PLAY      = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_TICK      = 2'd3;

   typedef struct packed {
      logic [TYPE_W-1:0]       req_type;
      logic [KF_W-1:0]         keyframe_index;
      logic [JOINT_W-1:0]      joint_index;
      logic signed [POS_W-1:0] position;
      logic [DUR_W-1:0]        duration_ms;
      logic [COUNT_W-1:0]      keyframe_count;
   } req_payload_type;

   typedef struct packed {
      logic [JOINT_W-1:0]      out_joint;
      logic signed [POS_W-1:0] out_position;
      logic                    const_velocity_mode;
      logic                    last_joint;
      logic                    last_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/kpi_ram.sv =====
// ----------------------------------------------------------------------------
// kpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kpi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 288
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kpi_div.sv =====
// ----------------------------------------------------------------------------
// kpi_div
// Shared restoring divider, one quotient bit per cycle. Used for segment
// point counts and for the rounded interpolation quotient.
// ----------------------------------------------------------------------------
`include "keyframe_pose_interpolator_assert.svh"

module kpi_div import kpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W:0]       shifted;
   logic                 fits;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(NUM_W);
         rem_in = '0;
         quo_in = div_req.dividend;
         den_in = div_req.divisor;
      end else if (run_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `KPI_ASSERT_IMP(a_no_restart, div_req.start, !run_ff)
   `KPI_ASSERT_IMP(a_nonzero_divisor, div_req.start, div_req.divisor != '0)
   `KPI_ASSERT_NXT(a_done_once, done_ff, !done_ff)

endmodule

// ===== rtl/core/keyframe_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator
// Keyframe motion player: page store of joint poses and segment durations,
// one frame of joint beats per playing tick, linear steps between keyframes.
//
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_stall  req_payload_type
// rsp      out  rsp_valid / rsp_stall  rsp_payload_type
// csr      in   csr_write_en           frame_period_ms (10 bits)
//
// Store beats complete when accepted. A play beat checks segments in turn, one
// pass of the shared divider each, until one has points. A tick beat while
// playing gives JOINTS rsp beats; each joint is read, then interpolated in a
// 30-step divider pass (read only on a single-pose page), after the segment
// checks when a segment ends. Reset is synchronous; req is stalled while the
// sequencer is busy, and rsp stall holds the sequencer at the output register.
// ----------------------------------------------------------------------------
`include "keyframe_pose_interpolator_assert.svh"

module keyframe_pose_interpolator import kpi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_data,
   input  logic                csr_write_en,
   input  logic [PERIOD_W-1:0] csr_write_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SEEK  = 4'd1;
   localparam logic [3:0] S_SEEKW = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_RDB   = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_DIVS  = 4'd6;
   localparam logic [3:0] S_DIVW  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   localparam logic [JOINT_W-1:0] JOINT_LAST = JOINT_W'(JOINTS - 1);

   logic [3:0]           state_ff, state_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [SEG_W-1:0]     page_len_ff, page_len_in;
   logic [KF_IDX_W-1:0]  seg_ff, seg_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [STEP_W-1:0]    pts_ff, pts_in;
   logic                 playing_ff, playing_in;
   logic [SEG_W-1:0]     seek_seg_ff, seek_seg_in;
   logic                 seek_ret_ff, seek_ret_in;
   logic [JOINT_W-1:0]   joint_ff, joint_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [KF_IDX_W-1:0]    cur_seg_ff, cur_seg_in;
   logic [STEP_W-1:0]      cur_j_ff, cur_j_in;
   logic [STEP_W-1:0]      cur_pts_ff, cur_pts_in;
   logic                   single_ff, single_in;
   logic signed [POS_W-1:0]  a_ff, a_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [POS_W-1:0]  res_ff, res_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic                 rsp_free;
   logic                 rsp_load;
   logic                 dur_we;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [POS_W-1:0]     ram_rd_data;
   logic [ADDR_W-1:0]    a_addr;
   logic [ADDR_W-1:0]    b_addr;
   logic [PERIOD_W-1:0]  per_eff;
   logic [DUR_W-1:0]     dur_cur;
   logic [DUR_W:0]       pnum;
   logic [SEG_W-1:0]     play_len;
   logic [STEP_W:0]      step_next;
   logic [STEP_W-1:0]    pts_safe;
   logic [STEP_W-1:0]    pts_cap;
   logic signed [DIFF_W-1:0] diff;
   logic [PROD_W-1:0]    prod_abs;
   logic [MAG_W-1:0]     mag;
   logic [POS_W-1:0]     q;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   kpi_ram #(
      .WIDTH (POS_W),
      .DEPTH (PAGE_DEPTH * JOINTS)
   ) u_pose_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.position),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // read ahead: the address is the segment the next cycle checks
   kpi_ram #(
      .WIDTH (DUR_W),
      .DEPTH (PAGE_DEPTH)
   ) u_dur_ram (
      .clock   (clock),
      .wr_en   (dur_we),
      .wr_addr (KF_IDX_W'(req_data.keyframe_index)),
      .wr_data (req_data.duration_ms),
      .rd_addr (seek_seg_in[KF_IDX_W-1:0]),
      .rd_data (dur_cur)
   );

   kpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign ram_wr_addr = ADDR_W'(int'(req_data.keyframe_index) * JOINTS
                                + int'(req_data.joint_index));
   assign a_addr = ADDR_W'(int'(cur_seg_ff) * JOINTS + int'(joint_ff));
   assign b_addr = ADDR_W'((int'(cur_seg_ff) + 1) * JOINTS + int'(joint_ff));

   assign per_eff  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign pnum     = (DUR_W+1)'(dur_cur) + (DUR_W+1)'(per_eff) - (DUR_W+1)'(1);
   assign play_len = (int'(req_data.keyframe_count) > PAGE_DEPTH) ? SEG_W'(PAGE_DEPTH)
                     : SEG_W'(req_data.keyframe_count);
   assign step_next = (STEP_W+1)'(step_ff) + (STEP_W+1)'(1);
   assign pts_safe  = (pts_ff == '0) ? STEP_W'(1) : pts_ff;
   assign pts_cap   = (div_rsp.quotient > NUM_W'(MAX_POINTS)) ? STEP_W'(MAX_POINTS)
                      : div_rsp.quotient[STEP_W-1:0];
   assign diff      = DIFF_W'($signed(ram_rd_data)) - DIFF_W'(a_ff);
   assign prod_abs  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign mag       = prod_abs[MAG_W-1:0];
   assign q         = div_rsp.quotient[POS_W-1:0];

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      page_len_in  = page_len_ff;
      seg_in       = seg_ff;
      step_in      = step_ff;
      pts_in       = pts_ff;
      playing_in   = playing_ff;
      seek_seg_in  = seek_seg_ff;
      seek_ret_in  = seek_ret_ff;
      joint_in     = joint_ff;
      cur_seg_in   = cur_seg_ff;
      cur_j_in     = cur_j_ff;
      cur_pts_in   = cur_pts_ff;
      single_in    = single_ff;
      a_in         = a_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      dur_we       = 1'b0;
      ram_we       = 1'b0;
      ram_rd_addr  = a_addr;
      rsp_load     = 1'b0;
      div_req      = '0;

      rsp_data_in.out_joint           = joint_ff;
      rsp_data_in.out_position        = res_ff;
      rsp_data_in.const_velocity_mode = single_ff;
      rsp_data_in.last_joint          = (joint_ff == JOINT_LAST);
      rsp_data_in.last_frame          = !playing_ff;

      if (csr_write_en) begin
         period_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.req_type)
                  REQ_STORE_POS: begin
                     ram_we = (int'(req_data.keyframe_index) < PAGE_DEPTH)
                              && (int'(req_data.joint_index) < JOINTS);
                  end
                  REQ_STORE_DUR: begin
                     dur_we = (int'(req_data.keyframe_index) < PAGE_DEPTH);
                  end
                  REQ_PLAY: begin
                     page_len_in = play_len;
                     if (play_len == SEG_W'(1)) begin
                        playing_in = 1'b1;
                        seg_in     = '0;
                        step_in    = '0;
                        pts_in     = '0;
                     end else begin
                        seek_seg_in = '0;
                        seek_ret_in = 1'b0;
                        state_in    = S_SEEK;
                     end
                  end
                  REQ_TICK: begin
                     if (playing_ff) begin
                        joint_in = '0;
                        if (page_len_ff == SEG_W'(1)) begin
                           single_in  = 1'b1;
                           cur_seg_in = '0;
                           playing_in = 1'b0;
                           state_in   = S_RDA;
                        end else begin
                           single_in  = 1'b0;
                           cur_seg_in = seg_ff;
                           cur_j_in   = step_ff;
                           cur_pts_in = pts_safe;
                           if (step_next >= (STEP_W+1)'(pts_safe)) begin
                              seek_seg_in = SEG_W'(seg_ff) + SEG_W'(1);
                              seek_ret_in = 1'b1;
                              state_in    = S_SEEK;
                           end else begin
                              step_in  = step_next[STEP_W-1:0];
                              state_in = S_RDA;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEEK: begin
            if ((page_len_ff >= SEG_W'(2)) && (seek_seg_ff < page_len_ff - SEG_W'(1))) begin
               div_req.start    = 1'b1;
               div_req.dividend = NUM_W'(pnum);
               div_req.divisor  = DEN_W'(per_eff);
               state_in         = S_SEEKW;
            end else begin
               playing_in = 1'b0;
               seg_in     = '0;
               step_in    = '0;
               pts_in     = '0;
               state_in   = seek_ret_ff ? S_RDA : S_IDLE;
            end
         end
         S_SEEKW: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient != '0) begin
                  seg_in     = seek_seg_ff[KF_IDX_W-1:0];
                  pts_in     = pts_cap;
                  step_in    = '0;
                  playing_in = 1'b1;
                  state_in   = seek_ret_ff ? S_RDA : S_IDLE;
               end else begin
                  seek_seg_in = seek_seg_ff + SEG_W'(1);
                  state_in    = S_SEEK;
               end
            end
         end
         S_RDA: begin
            ram_rd_addr = a_addr;
            state_in    = S_RDB;
         end
         S_RDB: begin
            ram_rd_addr = b_addr;
            a_in        = $signed(ram_rd_data);
            if (single_ff) begin
               res_in   = $signed(ram_rd_data);
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, cur_j_ff}) * diff;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'({mag, 1'b0}) + NUM_W'(cur_pts_ff);
            div_req.divisor  = DEN_W'({cur_pts_ff, 1'b0});
            state_in         = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               res_in   = prod_ff[PROD_W-1] ? $signed(POS_W'(a_ff) - q)
                                            : $signed(POS_W'(a_ff) + q);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (joint_ff == JOINT_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  joint_in = joint_ff + JOINT_W'(1);
                  state_in = S_RDA;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= PERIOD_W'(PERIOD_RESET);
         page_len_ff  <= '0;
         seg_ff       <= '0;
         step_ff      <= '0;
         pts_ff       <= '0;
         playing_ff   <= 1'b0;
         seek_seg_ff  <= '0;
         seek_ret_ff  <= 1'b0;
         joint_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         page_len_ff  <= page_len_in;
         seg_ff       <= seg_in;
         step_ff      <= step_in;
         pts_ff       <= pts_in;
         playing_ff   <= playing_in;
         seek_seg_ff  <= seek_seg_in;
         seek_ret_ff  <= seek_ret_in;
         joint_ff     <= joint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_seg_ff <= cur_seg_in;
      cur_j_ff   <= cur_j_in;
      cur_pts_ff <= cur_pts_in;
      single_ff  <= single_in;
      a_ff       <= a_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KPI_ASSERT_IMP(a_idle_cursor_clear, (state_ff == S_IDLE) && !playing_ff, (seg_ff == '0) && (step_ff == '0) && (pts_ff == '0))
   `KPI_ASSERT_IMP(a_step_in_segment, (state_ff == S_IDLE) && playing_ff && (page_len_ff != SEG_W'(1)), step_ff < pts_ff)
   `KPI_ASSERT_IMP(a_interp_bounded, (state_ff == S_DIVW) && div_rsp.done, div_rsp.quotient[NUM_W-1:POS_W] == '0)
   `KPI_ASSERT_NXT(a_frame_closes, (state_ff == S_OUT) && rsp_free && (joint_ff == JOINT_LAST), state_ff == S_IDLE)

endmodule

// ===== bench/tb_keyframe_pose_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_pose_interpolator
// Self-checking bench for the keyframe motion player. The page store is
// preloaded, a directed table covers the edge cases (idle ticks, single-pose
// pages, skipped segments, step cap, restart, empty page), then random pages
// are played under several frame periods and flow-control mixes. Every joint
// beat is checked field by field against a behavioral player model.
// ----------------------------------------------------------------------------
module tb_keyframe_pose_interpolator import kpi_pkg::*; ();

   localparam int REQ_W         = $bits(req_payload_type);
   localparam int SETTLE_CYCLES = 800;
   localparam int PHASES        = 6;
   localparam int PHASE_BEATS   = 12;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH}
      flow_mode_type;
   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      req_payload_type     beat;
      logic [PERIOD_W-1:0] period;
      bit                  typed;
      rsp_payload_type     first;
   } dir_row_type;

   localparam logic [PERIOD_W-1:0] PHASE_PERIOD [PHASES] = '{70, 1000, 1, 1023, 333, 9};
   localparam flow_mode_type PHASE_FLOW [PHASES] = '{FLOW_FREE, FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL, FLOW_BOTH, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_payload_type     req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_payload_type     rsp_data;
   logic                csr_write_en = 1'b0;
   logic [PERIOD_W-1:0] csr_write_data = '0;

   // player model state
   logic signed [POS_W-1:0] kf_pose [PAGE_DEPTH][JOINTS];
   logic [DUR_W-1:0]        kf_dur [PAGE_DEPTH];
   int unsigned             page_len = 0;
   int unsigned             seg_at = 0;
   int unsigned             step_at = 0;
   int unsigned             seg_steps = 0;
   bit                      is_playing = 1'b0;
   int unsigned             period_ms = PERIOD_RESET;

   rsp_payload_type expected_joints [$];
   dir_row_type     directed_rows [$];
   flow_mode_type   flow = FLOW_FREE;
   int unsigned     beats_counted = 0;
   int unsigned     joints_checked = 0;
   int unsigned     pages_closed = 0;
   int unsigned     mismatch_count = 0;

   keyframe_pose_interpolator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // player model
   // ------------------------------------------------------------------------
   function automatic void queue_joint(rsp_payload_type r);
      expected_joints = {expected_joints, r};
   endfunction

   function automatic int unsigned steps_for(int unsigned seg);
      int unsigned per;
      int unsigned p;
      per = (period_ms == 0) ? 1 : period_ms;
      p = (int'(kf_dur[seg]) + per - 1) / per;
      return (p > MAX_POINTS) ? MAX_POINTS : p;
   endfunction

   function automatic void enter_segment(int unsigned start_seg);
      int unsigned seg;
      int unsigned p;
      seg = start_seg;
      while (page_len >= 2 && seg < page_len - 1) begin
         p = steps_for(seg);
         if (p > 0) begin
            seg_at = seg;
            seg_steps = p;
            step_at = 0;
            is_playing = 1'b1;
            return;
         end
         seg++;
      end
      is_playing = 1'b0;
      seg_at = 0;
      step_at = 0;
      seg_steps = 0;
   endfunction

   // round half away from zero; result stays between a and b
   function automatic logic signed [POS_W-1:0] lerp(int a, int b, int unsigned j,
                                                    int unsigned pts);
      longint prod;
      longint mag;
      longint q;
      prod = longint'(j) * longint'(b - a);
      mag = (prod < 0) ? -prod : prod;
      q = (2 * mag + longint'(pts)) / (2 * longint'(pts));
      return (prod < 0) ? POS_W'(a - int'(q)) : POS_W'(a + int'(q));
   endfunction

   function automatic rsp_payload_type joint_beat(int unsigned m, logic signed [POS_W-1:0] pos,
                                                  bit cv, bit lf);
      rsp_payload_type r;
      r.out_joint = JOINT_W'(m);
      r.out_position = pos;
      r.const_velocity_mode = cv;
      r.last_joint = (m == JOINTS - 1);
      r.last_frame = lf;
      return r;
   endfunction

   function automatic void advance_player(req_payload_type b);
      int unsigned seg;
      int unsigned j;
      int unsigned pts;
      int unsigned m;
      bit last;
      case (b.req_type)
         REQ_STORE_POS: begin
            if (b.joint_index < JOINTS) kf_pose[b.keyframe_index][b.joint_index] = b.position;
         end
         REQ_STORE_DUR: kf_dur[b.keyframe_index] = b.duration_ms;
         REQ_PLAY: begin
            page_len = (b.keyframe_count > PAGE_DEPTH) ? PAGE_DEPTH : b.keyframe_count;
            if (page_len == 1) begin
               is_playing = 1'b1;
               seg_at = 0;
               step_at = 0;
               seg_steps = 0;
            end else begin
               enter_segment(0);
            end
         end
         REQ_TICK: begin
            if (is_playing && page_len == 1) begin
               for (m = 0; m < JOINTS; m++)
                  queue_joint(joint_beat(m, kf_pose[0][m], 1'b1, 1'b1));
               is_playing = 1'b0;
            end else if (is_playing) begin
               seg = seg_at;
               j = step_at;
               pts = (seg_steps != 0) ? seg_steps : 1;
               step_at = j + 1;
               if (step_at >= pts) enter_segment(seg + 1);
               last = !is_playing;
               for (m = 0; m < JOINTS; m++)
                  queue_joint(joint_beat(m,
                     lerp(kf_pose[seg][m], kf_pose[seg + 1][m], j, pts), 1'b0, last));
            end
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // beat builders; unused fields carry random junk
   // ------------------------------------------------------------------------
   function automatic req_payload_type junk_beat(logic [TYPE_W-1:0] kind);
      req_payload_type b;
      b = req_payload_type'(REQ_W'({$urandom(), $urandom()}));
      b.req_type = kind;
      return b;
   endfunction

   function automatic req_payload_type pos_beat(int unsigned kf, int unsigned joint, int pos);
      req_payload_type b;
      b = junk_beat(REQ_STORE_POS);
      b.keyframe_index = KF_W'(kf);
      b.joint_index = JOINT_W'(joint);
      b.position = POS_W'(pos);
      return b;
   endfunction

   function automatic req_payload_type dur_beat(int unsigned kf, int unsigned dur);
      req_payload_type b;
      b = junk_beat(REQ_STORE_DUR);
      b.keyframe_index = KF_W'(kf);
      b.duration_ms = DUR_W'(dur);
      return b;
   endfunction

   function automatic req_payload_type play_beat(int unsigned count);
      req_payload_type b;
      b = junk_beat(REQ_PLAY);
      b.keyframe_count = COUNT_W'(count);
      return b;
   endfunction

   function automatic dir_row_type as_row(req_payload_type b);
      return '{ROW_BEAT, b, '0, 1'b0, '0};
   endfunction

   // typed expectation for joint 0 of the frame
   function automatic dir_row_type with_first(req_payload_type b, int pos, bit cv, bit lf);
      return '{ROW_BEAT, b, '0, 1'b1, joint_beat(0, POS_W'(pos), cv, lf)};
   endfunction

   function automatic int unsigned pick_duration();
      int unsigned per;
      int unsigned roll;
      per = (period_ms == 0) ? 1 : period_ms;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 0;
      if (roll < 85) return $urandom_range(1, per * 3);
      return $urandom_range(0, 65535);
   endfunction

   // ------------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------------
   function automatic bit sender_rests();
      case (flow)
         FLOW_SENDER_IDLE: return $urandom_range(0, 99) < 58;
         FLOW_BOTH:        return $urandom_range(0, 99) < 7;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (flow)
         FLOW_RECEIVER_STALL: return $urandom_range(0, 99) < 58;
         FLOW_BOTH:           return $urandom_range(0, 99) < 7;
         default:             return 1'b0;
      endcase
   endfunction

   always @(negedge clock) rsp_stall <= receiver_stalls();

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_beat(input req_payload_type beat, input bit typed = 1'b0,
                            input rsp_payload_type first = '0);
      int unsigned queued_n;
      @(negedge clock);
      while (sender_rests()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      if (!(beat.req_type == REQ_TICK && !is_playing) &&
          !(beat.req_type == REQ_STORE_POS && beat.joint_index >= JOINTS))
         beats_counted++;
      queued_n = expected_joints.size();
      advance_player(beat);
      if (typed) begin
         if (expected_joints.size() == queued_n) queue_joint(first);
         else expected_joints[queued_n] = first;
      end
   endtask

   task automatic wait_for_drain(input int unsigned extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_joints.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      wait_for_drain(SETTLE_CYCLES);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      period_ms = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic play_random_page();
      int unsigned kfs;
      int unsigned roll;
      int unsigned i;
      int unsigned kf;
      int unsigned ticks_left;
      roll = $urandom_range(0, 99);
      if (roll < 6) kfs = 0;
      else if (roll < 12) kfs = $urandom_range(16, 31);
      else if (roll < 22) kfs = 1;
      else kfs = $urandom_range(2, 5);
      for (i = 0; i + 1 < kfs && i < 5; i++) send_beat(dur_beat(i, pick_duration()));
      repeat ($urandom_range(0, 4)) begin
         kf = ($urandom_range(0, 9) < 3 || kfs == 0) ? $urandom_range(0, 15)
            : $urandom_range(0, ((kfs > PAGE_DEPTH) ? PAGE_DEPTH : kfs) - 1);
         send_beat(pos_beat(kf, $urandom_range(0, JOINTS - 1), $urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 9) == 0)
         send_beat(pos_beat($urandom_range(0, 15), $urandom_range(JOINTS, 31),
                            $urandom_range(0, 65535)));
      send_beat(play_beat(kfs));
      ticks_left = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 24;
      while (is_playing && ticks_left > 0) begin
         if ($urandom_range(0, 19) == 0) begin
            send_beat(pos_beat($urandom_range(0, 15), $urandom_range(0, JOINTS - 1),
                               $urandom_range(0, 65535)));
         end else begin
            send_beat(junk_beat(REQ_TICK));
            ticks_left--;
         end
      end
      if ($urandom_range(0, 6) == 0) send_beat(junk_beat(REQ_TICK));
   endtask

   // ------------------------------------------------------------------------
   // result check
   // ------------------------------------------------------------------------
   function automatic string describe(rsp_payload_type r);
      return $sformatf("joint %0d pos %0d cv %0b last_joint %0b last_frame %0b",
                       r.out_joint, r.out_position, r.const_velocity_mode,
                       r.last_joint, r.last_frame);
   endfunction

   task automatic note_mismatch(input string what, input rsp_payload_type want,
                                input rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch, %s: expected %s, got %s", $realtime, what,
                  describe(want), describe(got));
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         joints_checked++;
         if (rsp_data.last_joint && rsp_data.last_frame) pages_closed++;
         if (expected_joints.size() == 0) begin
            note_mismatch("no beat pending", '0, rsp_data);
         end else begin
            want = expected_joints.pop_front();
            if (rsp_data.out_joint !== want.out_joint ||
                rsp_data.out_position !== want.out_position ||
                rsp_data.const_velocity_mode !== want.const_velocity_mode ||
                rsp_data.last_joint !== want.last_joint ||
                rsp_data.last_frame !== want.last_frame)
               note_mismatch("field", want, rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : run
      int unsigned kf;
      int unsigned m;
      int unsigned ph;
      int unsigned goal;
      int unsigned half;
      bit paused;
      foreach (kf_dur[i]) kf_dur[i] = '0;
      foreach (kf_pose[i, j]) kf_pose[i][j] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole store so no play reads an unwritten entry
      for (kf = 0; kf < PAGE_DEPTH; kf++) begin
         send_beat(dur_beat(kf, $urandom_range(0, 65535)));
         for (m = 0; m < JOINTS; m++) send_beat(pos_beat(kf, m, $urandom_range(0, 65535)));
      end

      flow = FLOW_BOTH;
      directed_rows = '{
         as_row(pos_beat(0, 0, 32767)),
         as_row(pos_beat(1, 0, -32768)),
         as_row(pos_beat(2, 31, 16'h5A5A)),
         as_row(dur_beat(0, 140)),
         as_row(dur_beat(1, 0)),
         as_row(dur_beat(2, 1)),
         as_row(junk_beat(REQ_TICK)),
         as_row(play_beat(1)),
         with_first(junk_beat(REQ_TICK), 32767, 1'b1, 1'b1),
         as_row(junk_beat(REQ_TICK)),
         as_row(play_beat(4)),
         with_first(junk_beat(REQ_TICK), 32767, 1'b0, 1'b0),
         with_first(junk_beat(REQ_TICK), -1, 1'b0, 1'b0),
         as_row(pos_beat(2, 0, 100)),
         with_first(junk_beat(REQ_TICK), 100, 1'b0, 1'b1),
         as_row(play_beat(31)),
         with_first(junk_beat(REQ_TICK), 32767, 1'b0, 1'b0),
         as_row(play_beat(0)),
         as_row(junk_beat(REQ_TICK)),
         '{ROW_CSR, '0, 10'd0, 1'b0, '0},
         as_row(dur_beat(0, 65535)),
         as_row(play_beat(2)),
         with_first(junk_beat(REQ_TICK), 32767, 1'b0, 1'b0),
         as_row(junk_beat(REQ_TICK)),
         as_row(play_beat(2)),
         with_first(junk_beat(REQ_TICK), 32767, 1'b0, 1'b0)
      };
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) write_period(directed_rows[i].period);
         else send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].first);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         write_period(PHASE_PERIOD[ph]);
         flow = PHASE_FLOW[ph];
         goal = beats_counted + PHASE_BEATS;
         half = beats_counted + PHASE_BEATS / 2;
         paused = 1'b0;
         while (beats_counted < goal) begin
            play_random_page();
            // hold off until the pipeline is empty once per phase
            if (!paused && beats_counted >= half) begin
               wait_for_drain(0);
               paused = 1'b1;
            end
         end
      end

      wait_for_drain(SETTLE_CYCLES);
      if (expected_joints.size() != 0)
         $display("%0d joint beats never arrived", expected_joints.size());
      $display("covered %0d request beats over frame periods 0 to 1023 and four flow mixes",
               beats_counted);
      $display("%0d joint beats compared, %0d pages closed, %0d mismatches",
               joints_checked, pages_closed, mismatch_count);
      if (mismatch_count == 0 && expected_joints.size() == 0) begin
         $display("tb_keyframe_pose_interpolator: PASS");
      end else begin
         $display("tb_keyframe_pose_interpolator: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("tb_keyframe_pose_interpolator: FAIL");
      $finish;
   end

endmodule
